/* rtl/core/midpoint_line_rasterizer_assert.svh */
// Assertion helpers; expect clk_i and rst_ni in scope.
`ifndef MIDPOINT_LINE_RASTERIZER_ASSERT_SVH
`define MIDPOINT_LINE_RASTERIZER_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define MLR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define MLR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Condition never holds.
`define MLR_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

/* rtl/core/mlr_pkg.sv */
package mlr_pkg;

  localparam int COORD_BITS  = 12;
  localparam int COLOR_BITS  = 24;
  localparam int DEC_BITS    = COORD_BITS + 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic [COLOR_BITS-1:0]      color_t;
  typedef logic signed [DEC_BITS-1:0] dec_t;

  typedef enum logic {
    MODE_START = 1'b0,
    MODE_STEP  = 1'b1
  } mode_e;

  // Classified beat handed from the front end to the line engine.
  typedef struct packed {
    logic   is_start;
    coord_t x_start;
    coord_t y_start;
    coord_t end_major;
    color_t color;
    dec_t   decision;
    dec_t   step_both;
    dec_t   step_major;
    logic   x_is_major;
    logic   x_neg;
    logic   y_neg;
    logic   first_last;
  } cmd_t;

endpackage

/* rtl/core/mlr_if.sv */
interface mlr_in_if import mlr_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   mode;
  coord_t x_start;
  coord_t y_start;
  coord_t x_end;
  coord_t y_end;
  color_t color;

  modport source (output valid, mode, x_start, y_start, x_end, y_end, color, input ready);
  modport sink   (input valid, mode, x_start, y_start, x_end, y_end, color, output ready);
endinterface

interface mlr_out_if import mlr_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t pixel_x;
  coord_t pixel_y;
  color_t pixel_color;
  logic   last;

  modport source (output valid, pixel_x, pixel_y, pixel_color, last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_color, last, output ready);
endinterface

/* rtl/core/mlr_front.sv */
module mlr_front import mlr_pkg::*; (
  mlr_in_if.sink cmd_i,
  input  logic   full_i,
  output logic   push_o,
  output cmd_t   cmd_o
);

  logic   x_neg, y_neg, x_major;
  coord_t dx, dy, maj, mnr;
  dec_t   two_mnr, two_maj, maj_ext;

  assign cmd_i.ready = !full_i;
  assign push_o      = cmd_i.valid && !full_i;

  always_comb begin
    x_neg   = cmd_i.x_end < cmd_i.x_start;
    y_neg   = cmd_i.y_end < cmd_i.y_start;
    dx      = x_neg ? cmd_i.x_start - cmd_i.x_end : cmd_i.x_end - cmd_i.x_start;
    dy      = y_neg ? cmd_i.y_start - cmd_i.y_end : cmd_i.y_end - cmd_i.y_start;
    x_major = dx > dy;
    maj     = x_major ? dx : dy;
    mnr     = x_major ? dy : dx;
    two_mnr = {{(DEC_BITS-COORD_BITS-1){1'b0}}, mnr, 1'b0};
    two_maj = {{(DEC_BITS-COORD_BITS-1){1'b0}}, maj, 1'b0};
    maj_ext = {{(DEC_BITS-COORD_BITS){1'b0}}, maj};

    cmd_o.is_start   = mode_e'(cmd_i.mode) == MODE_START;
    cmd_o.x_start    = cmd_i.x_start;
    cmd_o.y_start    = cmd_i.y_start;
    cmd_o.end_major  = x_major ? cmd_i.x_end : cmd_i.y_end;
    cmd_o.color      = cmd_i.color;
    cmd_o.decision   = two_mnr - maj_ext;
    cmd_o.step_both  = two_mnr - two_maj;
    cmd_o.step_major = two_mnr;
    cmd_o.x_is_major = x_major;
    cmd_o.x_neg      = x_neg;
    cmd_o.y_neg      = y_neg;
    cmd_o.first_last = (x_major ? cmd_i.x_start : cmd_i.y_start) == cmd_o.end_major;
  end

endmodule

/* rtl/core/mlr_queue.sv */
`include "midpoint_line_rasterizer_assert.svh"

module mlr_queue import mlr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t                 mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_BITS-1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == QCNT_BITS'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + QCNT_BITS'(1);
      2'b01:   cnt_d = cnt_q - QCNT_BITS'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= cmd_i;
  end

  `MLR_ASSERT_NEVER(a_cnt_bound, cnt_q > QCNT_BITS'(QUEUE_DEPTH), "queue count over depth")
  `MLR_ASSERT_SAME(a_pop_nonempty, pop_i, cnt_q != '0, "pop from empty queue")
  `MLR_ASSERT_NEVER(a_push_full, push_i && full_o, "push into full queue")

endmodule

/* rtl/core/mlr_back.sv */
`include "midpoint_line_rasterizer_assert.svh"

module mlr_back import mlr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  cmd_t       q_cmd_i,
  output logic       q_pop_o,
  mlr_out_if.source  pix_o
);

  coord_t cur_x_q, cur_x_d, cur_y_q, cur_y_d, end_major_q, end_major_d;
  dec_t   decision_q, decision_d, step_both_q, step_both_d, step_major_q, step_major_d;
  logic   x_is_major_q, x_is_major_d, x_neg_q, x_neg_d, y_neg_q, y_neg_d;
  logic   active_q, active_d;
  color_t color_q, color_d;

  logic   out_valid_q, out_valid_d, out_last_q, out_last_d;
  coord_t out_x_q, out_y_q;
  color_t out_color_q;

  logic   slot_free, emits, load, minor;
  coord_t nx, ny;

  function automatic coord_t step_coord(coord_t v, logic neg);
    return neg ? v - coord_t'(1) : v + coord_t'(1);
  endfunction

  assign slot_free = !out_valid_q || pix_o.ready;
  assign emits     = q_cmd_i.is_start || active_q;
  assign q_pop_o   = q_valid_i && (!emits || slot_free);
  assign load      = q_pop_o && emits;
  assign minor     = !decision_q[DEC_BITS-1];

  always_comb begin
    nx = cur_x_q;
    ny = cur_y_q;
    if (x_is_major_q) begin
      if (minor) ny = step_coord(cur_y_q, y_neg_q);
      nx = step_coord(cur_x_q, x_neg_q);
    end else begin
      if (minor) nx = step_coord(cur_x_q, x_neg_q);
      ny = step_coord(cur_y_q, y_neg_q);
    end
  end

  always_comb begin
    cur_x_d      = cur_x_q;
    cur_y_d      = cur_y_q;
    end_major_d  = end_major_q;
    decision_d   = decision_q;
    step_both_d  = step_both_q;
    step_major_d = step_major_q;
    x_is_major_d = x_is_major_q;
    x_neg_d      = x_neg_q;
    y_neg_d      = y_neg_q;
    active_d     = active_q;
    color_d      = color_q;
    out_last_d   = out_last_q;
    out_valid_d  = out_valid_q && !pix_o.ready;
    if (load) begin
      out_valid_d = 1'b1;
      if (q_cmd_i.is_start) begin
        cur_x_d      = q_cmd_i.x_start;
        cur_y_d      = q_cmd_i.y_start;
        end_major_d  = q_cmd_i.end_major;
        decision_d   = q_cmd_i.decision;
        step_both_d  = q_cmd_i.step_both;
        step_major_d = q_cmd_i.step_major;
        x_is_major_d = q_cmd_i.x_is_major;
        x_neg_d      = q_cmd_i.x_neg;
        y_neg_d      = q_cmd_i.y_neg;
        color_d      = q_cmd_i.color;
        out_last_d   = q_cmd_i.first_last;
      end else begin
        cur_x_d    = nx;
        cur_y_d    = ny;
        decision_d = decision_q + (minor ? step_both_q : step_major_q);
        out_last_d = (x_is_major_q ? nx : ny) == end_major_q;
      end
      active_d = !out_last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      end_major_q  <= '0;
      decision_q   <= '0;
      step_both_q  <= '0;
      step_major_q <= '0;
      x_is_major_q <= 1'b0;
      x_neg_q      <= 1'b0;
      y_neg_q      <= 1'b0;
      active_q     <= 1'b0;
      color_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      cur_x_q      <= cur_x_d;
      cur_y_q      <= cur_y_d;
      end_major_q  <= end_major_d;
      decision_q   <= decision_d;
      step_both_q  <= step_both_d;
      step_major_q <= step_major_d;
      x_is_major_q <= x_is_major_d;
      x_neg_q      <= x_neg_d;
      y_neg_q      <= y_neg_d;
      active_q     <= active_d;
      color_q      <= color_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // output beat payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_x_q     <= cur_x_d;
      out_y_q     <= cur_y_d;
      out_color_q <= color_d;
      out_last_q  <= out_last_d;
    end
  end

  assign pix_o.valid       = out_valid_q;
  assign pix_o.pixel_x     = out_x_q;
  assign pix_o.pixel_y     = out_y_q;
  assign pix_o.pixel_color = out_color_q;
  assign pix_o.last        = out_last_q;

  `MLR_ASSERT_NEXT(a_last_ends_line, load && out_last_d, !active_q, "line active past last")
  `MLR_ASSERT_SAME(a_no_drop, q_pop_o && (q_cmd_i.is_start || active_q), load, "beat dropped")
  `MLR_ASSERT_SAME(a_load_slot, load, slot_free, "output overwritten")

endmodule

/* rtl/core/midpoint_line_rasterizer.sv */
// channel | role | payload                                      | handshake
// cmd_i   | sink | mode, x_start, y_start, x_end, y_end, color  | valid & ready
// pix_o   | src  | pixel_x, pixel_y, pixel_color, last          | valid & ready
//
// One beat per cycle sustained while pix_o is ready; the engine takes start and step beats alike.
// An input beat is registered twice: queue write, then the output register.
// The engine step loop (one add, one increment or decrement, one compare) sets the rate.
// rst_ni is asynchronous, active low; it empties the queue and leaves no line active.
// A two-entry queue parts front and engine; a held pixel stalls the engine,
// and the input once both queue entries are taken.
module midpoint_line_rasterizer import mlr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  mlr_in_if.sink    cmd_i,
  mlr_out_if.source pix_o
);

  logic push, full, q_valid, pop;
  cmd_t push_cmd, q_cmd;

  mlr_front u_front (
    .cmd_i  (cmd_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  mlr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  mlr_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_cmd),
    .q_pop_o   (pop),
    .pix_o     (pix_o)
  );

endmodule
